// ===== hdl/fac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_pkg: shared constants of the fuzzy ART category unit
// Q1.15 constants, register indexes, reset values and a cap-at-one helper.
// ----------------------------------------------------------------------------
package fac_pkg;

  localparam int unsigned FEATURES_DEF = 16;

  localparam logic [15:0] ONE_Q15  = 16'h8000;
  localparam logic [15:0] HALF_Q15 = 16'h4000;

  typedef enum logic [1:0] {
    REG_ALPHA = 2'd0,
    REG_VIG   = 2'd1,
    REG_LR    = 2'd2
  } cfg_reg_e;

  localparam logic [15:0] ALPHA_RST = 16'd33;
  localparam logic [15:0] VIG_RST   = 16'd24576;
  localparam logic [15:0] LR_RST    = 16'd32768;

  function automatic logic [15:0] cap_one(input logic [15:0] v);
    cap_one = (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

endpackage

// ===== hdl/fac_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_queue: two-entry job queue
// Holds finished vectors between the element front end and the divider.
// ----------------------------------------------------------------------------
module fac_queue #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] data_o
);

  logic [DW-1:0] mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hdl/fac_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_front: element front end
// Takes elements, reads and updates the weight store, keeps the running sums
// and queues one job per finished vector.
// ----------------------------------------------------------------------------
module fac_front #(
  parameter int unsigned FEATURES = fac_pkg::FEATURES_DEF,
  parameter int unsigned DIM      = 2 * FEATURES,
  parameter int unsigned ACC_W    = $clog2(DIM * 32768 + 1),
  parameter int unsigned DW       = 3 * ACC_W + ACC_W + 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          kind_i,
  input  logic [15:0]   element_i,
  input  logic          last_i,
  input  logic [15:0]   alpha_i,
  input  logic [15:0]   lr_i,
  output logic          push_o,
  output logic [DW-1:0] push_data_o,
  input  logic          full_i
);

  localparam int unsigned IW    = $clog2(DIM);
  localparam int unsigned CNT_W = $clog2(DIM + 2);

  typedef enum logic {F_IDLE, F_CALC} fstate_e;

  fstate_e          state_q;
  logic [15:0]      mem_q [DIM];
  logic [15:0]      rd_q;
  logic [15:0]      elem_q;
  logic             last_q;
  logic             kind_q;
  logic [CNT_W-1:0] idx_q;
  logic [CNT_W-1:0] fill_q;
  logic             committed_q;
  logic [ACC_W-1:0] wsum_q;
  logic [ACC_W-1:0] min_acc_q, in_acc_q, res_acc_q;

  logic             accept;
  logic             pass_kind;
  logic             in_store;
  logic [15:0]      w, m, lr, nw;
  logic [31:0]      prod_a, prod_b, mix;
  logic [CNT_W-1:0] idx_d;
  logic [ACC_W-1:0] min_acc_d, in_acc_d, res_acc_d, wsum_d;
  logic [ACC_W:0]   den;
  logic             size_err;
  logic             wr_en;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != F_IDLE) || full_i;
  assign pass_kind  = (idx_q == '0) ? kind_i : kind_q;

  assign in_store = (idx_q < CNT_W'(DIM));
  assign w        = (idx_q < fill_q) ? rd_q : fac_pkg::ONE_Q15;
  assign m        = (elem_q < w) ? elem_q : w;
  assign lr       = committed_q ? fac_pkg::cap_one(lr_i) : fac_pkg::ONE_Q15;
  assign prod_a   = lr * m;
  assign prod_b   = (fac_pkg::ONE_Q15 - lr) * w;
  assign mix      = prod_a + prod_b + 32'(fac_pkg::HALF_Q15);
  assign nw       = mix[30:15];

  assign idx_d     = (idx_q < CNT_W'(DIM + 1)) ? idx_q + CNT_W'(1) : idx_q;
  assign min_acc_d = (in_store && !kind_q) ? min_acc_q + ACC_W'(m) : min_acc_q;
  assign in_acc_d  = (in_store && !kind_q) ? in_acc_q + ACC_W'(elem_q) : in_acc_q;
  assign res_acc_d = (in_store && kind_q) ? res_acc_q + ACC_W'(w - nw) : res_acc_q;
  assign wsum_d    = (res_acc_d <= wsum_q) ? wsum_q - res_acc_d : '0;
  assign den       = {1'b0, wsum_q} + (ACC_W + 1)'(alpha_i);
  assign size_err  = (idx_d != CNT_W'(DIM));
  assign wr_en     = (state_q == F_CALC) && in_store && kind_q;

  assign push_o      = (state_q == F_CALC) && last_q;
  assign push_data_o = {kind_q, size_err, min_acc_d, in_acc_d, res_acc_d, den};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem_q[idx_q[IW-1:0]];
    end
    if (wr_en) begin
      mem_q[idx_q[IW-1:0]] <= nw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      elem_q      <= '0;
      last_q      <= 1'b0;
      kind_q      <= 1'b0;
      idx_q       <= '0;
      fill_q      <= '0;
      committed_q <= 1'b0;
      wsum_q      <= ACC_W'(DIM * 32768);
      min_acc_q   <= '0;
      in_acc_q    <= '0;
      res_acc_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (accept) begin
            elem_q  <= fac_pkg::cap_one(element_i);
            last_q  <= last_i;
            kind_q  <= pass_kind;
            state_q <= F_CALC;
          end
        end
        F_CALC: begin
          state_q <= F_IDLE;
          // writes run upwards from index zero, so a fill mark tracks them
          if (wr_en && (idx_q >= fill_q)) fill_q <= idx_d;
          if (last_q) begin
            idx_q     <= '0;
            min_acc_q <= '0;
            in_acc_q  <= '0;
            res_acc_q <= '0;
            if (kind_q) begin
              wsum_q      <= wsum_d;
              committed_q <= 1'b1;
            end
          end else begin
            idx_q     <= idx_d;
            min_acc_q <= min_acc_d;
            in_acc_q  <= in_acc_d;
            res_acc_q <= res_acc_d;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i) else $error("job pushed into full queue");
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(DIM)) else $error("fill mark beyond store");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= CNT_W'(DIM + 1)) else $error("element index beyond saturation");

endmodule

// ===== hdl/fac_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_back: end-of-vector divider
// Pops a job, runs a restoring divider one quotient bit a cycle for the
// evaluate ratios, takes the mean residual by reciprocal multiplication and
// presents the result beat.
// ----------------------------------------------------------------------------
module fac_back #(
  parameter int unsigned FEATURES = fac_pkg::FEATURES_DEF,
  parameter int unsigned DIM      = 2 * FEATURES,
  parameter int unsigned ACC_W    = $clog2(DIM * 32768 + 1),
  parameter int unsigned DW       = 3 * ACC_W + ACC_W + 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  logic [DW-1:0] q_data_i,
  output logic          pop_o,
  input  logic [15:0]   vig_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          kind_done_o,
  output logic [15:0]   choice_value_o,
  output logic [15:0]   match_ratio_o,
  output logic          match_ok_o,
  output logic [16:0]   mean_residual_o,
  output logic          size_error_o
);

  localparam int unsigned NW = ACC_W + 15;
  localparam int unsigned RW = ACC_W + 2;
  localparam int unsigned SW = $clog2(NW);
  localparam int unsigned PW = 2 * ACC_W + 17;
  // exact floor division by FEATURES for any residual below 2^ACC_W
  localparam int unsigned RSH = ACC_W + $clog2(FEATURES);
  localparam longint unsigned RMUL =
    ((64'd1 << RSH) + 64'(FEATURES) - 64'd1) / 64'(FEATURES);

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_OUT} bstate_e;
  typedef enum logic [1:0] {OP_CHOICE, OP_RATIO} op_e;

  bstate_e          state_q;
  op_e              op_q;
  logic [ACC_W-1:0] min_q, inp_q;
  logic [ACC_W:0]   den_q;
  logic [NW-1:0]    dvd_q, quo_q;
  logic [ACC_W:0]   div_q;
  logic [RW-1:0]    rem_q;
  logic [SW-1:0]    cnt_q;

  logic             j_kind, j_err;
  logic [ACC_W-1:0] j_min, j_inp, j_res;
  logic [ACC_W:0]   j_den;
  logic [RW-1:0]    rem_sh, rem_nx;
  logic             ge;
  logic [NW-1:0]    quo_nx;
  logic [15:0]      capped;
  logic [NW:0]      vig_prod;
  logic [PW-1:0]    mean_prod;

  assign {j_kind, j_err, j_min, j_inp, j_res, j_den} = q_data_i;

  assign rem_sh    = {rem_q[RW-2:0], dvd_q[NW-1]};
  assign ge        = (rem_sh >= {1'b0, div_q});
  assign rem_nx    = ge ? rem_sh - {1'b0, div_q} : rem_sh;
  assign quo_nx    = {quo_q[NW-2:0], ge};
  assign capped    = (quo_nx > NW'(32768)) ? fac_pkg::ONE_Q15 : quo_nx[15:0];
  assign vig_prod  = vig_i * inp_q;
  assign mean_prod = PW'(j_res) * PW'(RMUL);

  assign pop_o       = (state_q == B_IDLE) && q_valid_i;
  assign out_valid_o = (state_q == B_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= B_IDLE;
      op_q            <= OP_CHOICE;
      min_q           <= '0;
      inp_q           <= '0;
      den_q           <= '0;
      dvd_q           <= '0;
      quo_q           <= '0;
      div_q           <= '0;
      rem_q           <= '0;
      cnt_q           <= '0;
      kind_done_o     <= 1'b0;
      choice_value_o  <= '0;
      match_ratio_o   <= '0;
      match_ok_o      <= 1'b0;
      mean_residual_o <= '0;
      size_error_o    <= 1'b0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (q_valid_i) begin
            min_q          <= j_min;
            inp_q          <= j_inp;
            den_q          <= j_den;
            kind_done_o    <= j_kind;
            size_error_o   <= j_err;
            choice_value_o <= '0;
            match_ratio_o  <= '0;
            match_ok_o     <= 1'b0;
            rem_q          <= '0;
            quo_q          <= '0;
            cnt_q          <= '0;
            op_q           <= OP_CHOICE;
            dvd_q          <= {j_min, 15'd0};
            div_q          <= j_den;
            if (j_kind) begin
              mean_residual_o <= mean_prod[RSH +: 17];
              state_q         <= B_OUT;
            end else begin
              mean_residual_o <= '0;
              state_q         <= B_DIV;
            end
          end
        end
        B_DIV: begin
          if (cnt_q == SW'(NW - 1)) begin
            rem_q <= '0;
            quo_q <= '0;
            cnt_q <= '0;
            case (op_q)
              OP_CHOICE: begin
                choice_value_o <= (den_q == '0) ? 16'd0 : capped;
                op_q           <= OP_RATIO;
                dvd_q          <= {min_q, 15'd0};
                div_q          <= {1'b0, inp_q};
              end
              OP_RATIO: begin
                match_ratio_o <= (inp_q == '0) ? 16'd0 : capped;
                match_ok_o    <= (inp_q != '0) && ({1'b0, min_q, 15'd0} >= vig_prod);
                state_q       <= B_OUT;
              end
              default: state_q <= B_OUT;
            endcase
          end else begin
            dvd_q <= {dvd_q[NW-2:0], 1'b0};
            rem_q <= rem_nx;
            quo_q <= quo_nx;
            cnt_q <= cnt_q + SW'(1);
          end
        end
        B_OUT: begin
          if (!out_stall_i) state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  a_eval_no_resid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !kind_done_o) |-> (mean_residual_o == '0))
    else $error("evaluate beat carries a residual");
  a_learn_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && match_ok_o) |-> !kind_done_o)
    else $error("learn beat reports a match");
  a_ratio_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (choice_value_o <= fac_pkg::ONE_Q15) &&
                    (match_ratio_o <= fac_pkg::ONE_Q15))
    else $error("ratio above one");

endmodule

// ===== hdl/fuzzy_art_category_unit_top.sv =====
`timescale 1ns / 1ps
// Front end: each element is read in F_IDLE (weight read), then updated in
// F_CALC; input stalls in F_CALC, so the next element waits for the update.
// To the result beat: an evaluate job passes the queue, the pop and two
// divider quotients; a learn job passes the queue and the pop, no divider.
// An evaluate job holds the divider, so a run of them stalls on the full queue.
// Reset: weights read as one, weight sum 32768*2*FEATURES, uncommitted.
// ----------------------------------------------------------------------------
// fuzzy_art_category_unit_top: one fuzzy ART category
// Element front end, job queue and divider back end; config registers.
// ----------------------------------------------------------------------------
module fuzzy_art_category_unit_top #(
  parameter int unsigned FEATURES = fac_pkg::FEATURES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [15:0] element_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_done_o,
  output logic [15:0] choice_value_o,
  output logic [15:0] match_ratio_o,
  output logic        match_ok_o,
  output logic [16:0] mean_residual_o,
  output logic        size_error_o
);

  localparam int unsigned DIM   = 2 * FEATURES;
  localparam int unsigned ACC_W = $clog2(DIM * 32768 + 1);
  localparam int unsigned DW    = 3 * ACC_W + ACC_W + 3;

  logic [15:0]   alpha_q, vig_q, lr_q;
  logic          push, full, pop, q_valid;
  logic [DW-1:0] push_data, q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= fac_pkg::ALPHA_RST;
      vig_q   <= fac_pkg::VIG_RST;
      lr_q    <= fac_pkg::LR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fac_pkg::REG_ALPHA: alpha_q <= cfg_data_i;
        fac_pkg::REG_VIG:   vig_q   <= cfg_data_i;
        fac_pkg::REG_LR:    lr_q    <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  fac_front #(.FEATURES(FEATURES), .DIM(DIM), .ACC_W(ACC_W), .DW(DW)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .element_i, .last_i,
    .alpha_i(alpha_q), .lr_i(lr_q),
    .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  fac_queue #(.DW(DW)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .data_o(q_data)
  );

  fac_back #(.FEATURES(FEATURES), .DIM(DIM), .ACC_W(ACC_W), .DW(DW)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(q_data), .pop_o(pop),
    .vig_i(vig_q), .out_valid_o, .out_stall_i, .kind_done_o, .choice_value_o,
    .match_ratio_o, .match_ok_o, .mean_residual_o, .size_error_o
  );

endmodule

// ===== sim/tb_fuzzy_art_category_unit_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fuzzy_art_category_unit_top: self-checking bench for one fuzzy ART category
// Streams evaluate and learn vectors with random gaps and output stalls,
// predicts every result beat from a local model of the category and
// compares field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_fuzzy_art_category_unit_top;

  localparam int unsigned NFEAT = fac_pkg::FEATURES_DEF;
  localparam int unsigned DIM   = 2 * NFEAT;

  typedef struct packed {
    logic        kind_done;
    logic [15:0] choice_value;
    logic [15:0] match_ratio;
    logic        match_ok;
    logic [16:0] mean_residual;
    logic        size_error;
  } cat_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = 1'b0;
  logic [15:0] element_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_done_o;
  logic [15:0] choice_value_o;
  logic [15:0] match_ratio_o;
  logic        match_ok_o;
  logic [16:0] mean_residual_o;
  logic        size_error_o;

  fuzzy_art_category_unit_top #(.FEATURES(NFEAT)) u_dut (.*);

  always #5 clk_i = ~clk_i;

  // category model
  logic [15:0] m_alpha, m_vig, m_lr;
  logic [15:0] m_weight [DIM];
  longint unsigned m_wsum, m_min_acc, m_in_acc, m_res_acc;
  int unsigned m_idx;
  bit m_committed, m_kind;

  cat_result_t expected_q[$];
  int errors = 0;
  int n_results = 0, n_items = 0;
  bit stall_busy = 1'b0;

  function automatic longint unsigned cap1(longint unsigned v);
    return (v > 32768) ? 64'd32768 : v;
  endfunction

  task automatic model_reset();
    for (int i = 0; i < DIM; i++) m_weight[i] = fac_pkg::ONE_Q15;
    m_wsum = 32768 * DIM;
    m_committed = 0;
    m_alpha = fac_pkg::ALPHA_RST; m_vig = fac_pkg::VIG_RST; m_lr = fac_pkg::LR_RST;
    m_idx = 0; m_min_acc = 0; m_in_acc = 0; m_res_acc = 0; m_kind = 0;
  endtask

  task automatic predict_category(input bit kind, input logic [15:0] elem, input bit lst);
    longint unsigned e, w, mn, lr, nw, num, den;
    cat_result_t r;
    e = cap1(elem);
    if (m_idx == 0) m_kind = kind;
    if (m_idx < DIM) begin
      w = m_weight[m_idx];
      mn = (e < w) ? e : w;
      if (!m_kind) begin
        m_min_acc += mn;
        m_in_acc += e;
      end else begin
        lr = m_committed ? cap1(m_lr) : 64'd32768;
        nw = (lr * mn + (32768 - lr) * w + 16384) >> 15;
        m_res_acc += w - nw;
        m_weight[m_idx] = nw[15:0];
      end
    end
    if (m_idx < DIM + 1) m_idx++;
    if (lst) begin
      r = '0;
      r.kind_done = m_kind;
      r.size_error = (m_idx != DIM);
      if (!m_kind) begin
        den = m_alpha + m_wsum;
        num = m_min_acc * 32768;
        if (den != 0) r.choice_value = 16'(cap1(num / den));
        if (m_in_acc != 0) begin
          r.match_ratio = 16'(cap1(num / m_in_acc));
          r.match_ok = (num >= m_vig * m_in_acc);
        end
      end else begin
        m_wsum = (m_res_acc <= m_wsum) ? m_wsum - m_res_acc : 0;
        r.mean_residual = 17'((m_res_acc / NFEAT) & 17'h1FFFF);
        m_committed = 1;
      end
      expected_q = {expected_q, r};
      m_idx = 0; m_min_acc = 0; m_in_acc = 0; m_res_acc = 0; m_kind = 0;
    end
  endtask

  function automatic int gap_len();
    int p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // send one beat; hold until accepted
  task automatic send_beat(input bit kind, input logic [15:0] elem, input bit lst,
                           input bit allow_gap);
    int g;
    g = allow_gap ? gap_len() : 0;
    repeat (g) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    element_i <= elem;
    last_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_category(kind, elem, lst);
    n_items++;
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(input fac_pkg::cfg_reg_e idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      fac_pkg::REG_ALPHA: m_alpha = val;
      fac_pkg::REG_VIG:   m_vig = val;
      default:            m_lr = val;
    endcase
  endtask

  function automatic logic [15:0] rand_elem();
    int p = $urandom_range(0, 9);
    if (p == 0) return 16'd0;
    if (p == 1) return fac_pkg::ONE_Q15;
    if (p == 2) return 16'($urandom_range(32769, 65535));
    return 16'($urandom_range(0, 32768));
  endfunction

  // vector of given length; complement coding when requested and well formed
  task automatic send_vector(input bit kind, input int len, input bit coded, input bit gaps);
    logic [15:0] half [NFEAT];
    logic [15:0] v;
    for (int i = 0; i < NFEAT; i++) half[i] = 16'($urandom_range(0, 32768));
    for (int i = 0; i < len; i++) begin
      if (coded && len == DIM)
        v = (i < NFEAT) ? half[i] : 16'(32768 - half[i - NFEAT]);
      else
        v = rand_elem();
      send_beat((i == 0) ? kind : 1'($urandom_range(0, 1)), v, i == len - 1, gaps);
    end
  endtask

  task automatic test_directed();
    // random evaluate vector, then all zero input: zero input total
    send_vector(1'b0, DIM, 1'b0, 1'b0);
    for (int i = 0; i < DIM; i++) send_beat(1'b0, 16'd0, i == DIM - 1, 1'b0);
    // over-range elements, first learn on uncommitted category
    for (int i = 0; i < DIM; i++) send_beat(1'b1, 16'hFFFF, i == DIM - 1, 1'b0);
    send_vector(1'b1, DIM, 1'b1, 1'b0);
    // short and long vectors
    send_beat(1'b0, 16'd1234, 1'b1, 1'b0);
    send_vector(1'b0, DIM + 3, 1'b0, 1'b0);
    send_vector(1'b1, 5, 1'b0, 1'b0);
    go_idle();
  endtask

  task automatic test_config_extremes();
    write_reg(fac_pkg::REG_ALPHA, 16'd0);
    write_reg(fac_pkg::REG_VIG, 16'd0);
    write_reg(fac_pkg::REG_LR, 16'd0);
    send_vector(1'b1, DIM, 1'b1, 1'b1);
    send_vector(1'b0, DIM, 1'b1, 1'b1);
    go_idle();
    write_reg(fac_pkg::REG_ALPHA, 16'd32768);
    write_reg(fac_pkg::REG_VIG, 16'd32768);
    write_reg(fac_pkg::REG_LR, 16'hFFFF);
    send_vector(1'b0, DIM, 1'b1, 1'b1);
    send_vector(1'b1, DIM, 1'b1, 1'b1);
    go_idle();
  endtask

  task automatic test_random(input int target);
    int p, len;
    while (n_items < target) begin
      if ($urandom_range(0, 149) == 0) begin
        go_idle();
        write_reg(fac_pkg::REG_ALPHA, 16'($urandom));
        write_reg(fac_pkg::REG_VIG, 16'($urandom_range(0, 32768)));
        write_reg(fac_pkg::REG_LR, 16'($urandom_range(0, 32768)));
      end
      p = $urandom_range(0, 9);
      if (p < 8) len = DIM;
      else len = $urandom_range(1, DIM + 6);
      send_vector(1'($urandom_range(0, 2) == 0), len, p < 7, $urandom_range(0, 3) != 0);
    end
    go_idle();
  endtask

  // output stall generator
  always @(posedge clk_i) begin
    if (stall_busy && $urandom_range(0, 3) == 0) out_stall_i <= 1'b0;
    else if (!stall_busy) out_stall_i <= ($urandom_range(0, 2) == 0);
  end
  initial begin
    forever begin
      repeat ($urandom_range(300, 900)) @(posedge clk_i);
      stall_busy = 1'b1;
      repeat ($urandom_range(200, 500)) @(posedge clk_i);
      stall_busy = 1'b0;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    cat_result_t got, exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{kind_done_o, choice_value_o, match_ratio_o, match_ok_o,
              mean_residual_o, size_error_o};
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h", $time, got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got.kind_done != exp_r.kind_done) begin
          errors++;
          $display("%0t: kind_done exp %0d got %0d", $time, exp_r.kind_done, got.kind_done);
        end
        if (got.choice_value != exp_r.choice_value) begin
          errors++;
          $display("%0t: choice_value exp %0d got %0d", $time,
                   exp_r.choice_value, got.choice_value);
        end
        if (got.match_ratio != exp_r.match_ratio) begin
          errors++;
          $display("%0t: match_ratio exp %0d got %0d", $time,
                   exp_r.match_ratio, got.match_ratio);
        end
        if (got.match_ok != exp_r.match_ok) begin
          errors++;
          $display("%0t: match_ok exp %0d got %0d", $time, exp_r.match_ok, got.match_ok);
        end
        if (got.mean_residual != exp_r.mean_residual) begin
          errors++;
          $display("%0t: mean_residual exp %0d got %0d", $time,
                   exp_r.mean_residual, got.mean_residual);
        end
        if (got.size_error != exp_r.size_error) begin
          errors++;
          $display("%0t: size_error exp %0d got %0d", $time,
                   exp_r.size_error, got.size_error);
        end
      end
    end
  end

  initial begin
    model_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random(1850);
    $display("Sent %0d element beats, checked %0d result beats", n_items, n_results);
    $display("Covered evaluate and learn passes, size errors and register extremes");
    if (errors == 0 && expected_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
